// ===== sv/ohc_pkg.sv =====
// ----------------------------------------------------------------------------
// ohc_pkg
// Types, status codes and checksum helper shared by the OSPF header checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ohc_pkg;

  // Byte counter width and its saturation value
  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] COUNT_MAX = 17'h1FFFF;

  // Header lengths per version
  localparam logic [CountW-1:0] HDR_V2 = 17'd24;
  localparam logic [CountW-1:0] HDR_V3 = 17'd16;

  // Version byte values
  localparam logic [7:0] VER_2 = 8'd2;
  localparam logic [7:0] VER_3 = 8'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_VER   = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_LEN_MISM  = 3'd4;
  localparam logic [2:0] ST_CSUM_MISM = 3'd5;

  // Register indexes on the configuration port
  localparam logic REG_V2_MASK = 1'b0;
  localparam logic REG_V3_MASK = 1'b1;

  // One received byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // One header check result
  typedef struct packed {
    logic [2:0]  status;
    logic        is_v3;
    logic [7:0]  pkt_type;
    logic [31:0] router_id;
    logic [31:0] area_id;
    logic [15:0] auth_type;
    logic [63:0] auth_data;
    logic [7:0]  instance_id;
    logic [4:0]  body_offset;
  } result_t;

  // Per-byte control into the checksum accumulator
  typedef struct packed {
    logic       fire;   // byte transfer this cycle
    logic       pair;   // byte closes a 16-bit word
    logic       pad;    // odd-length tail word to be added
    logic       clear;  // end of packet, restart the sum
    logic [7:0] sbyte;  // byte as summed (masked fields zeroed)
  } csum_step_t;

  // Ones-complement add with full end-around carry
  function automatic logic [15:0] csum_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/ohc_csum.sv =====
// ----------------------------------------------------------------------------
// ohc_csum
// Internet checksum accumulator: pairs bytes into big-endian words and keeps
// the running ones-complement sum; gives the final sum on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ohc_csum (
  input  wire                 clk,
  input  wire                 rst,
  input  ohc_pkg::csum_step_t step,
  output logic [15:0]         final_sum
);

  logic [15:0] running_sum;
  logic [7:0]  high_byte_hold;
  logic [15:0] sum_next;
  logic [7:0]  hold_next;

  // Word pairing and the odd-length tail
  always_comb begin
    hold_next = step.pair ? high_byte_hold : step.sbyte;
    sum_next  = step.pair ? ohc_pkg::csum_add(running_sum, {high_byte_hold, step.sbyte})
                          : running_sum;
    final_sum = step.pad ? ohc_pkg::csum_add(sum_next, {hold_next, 8'h00}) : sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      high_byte_hold <= '0;
    end else if (step.fire) begin
      if (step.clear) begin
        running_sum    <= '0;
        high_byte_hold <= '0;
      end else begin
        running_sum    <= sum_next;
        high_byte_hold <= hold_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/ospf_header_checker_core.sv =====
// ----------------------------------------------------------------------------
// ospf_header_checker_core
// Byte-stream OSPF v2/v3 header checker with Internet checksum verification.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) carries one packet byte per
//   transfer, wire order, with last_byte set on the final byte.
//   result channel (result_valid/result_ready/result) carries one status and
//   the captured header fields per packet.
//   Throughput: one byte per cycle unless a last byte stalls. Each byte updates
//   the header capture registers and the checksum accumulator in the cycle it
//   is transferred. Latency: the result is valid in the cycle after the last
//   byte transfer. The result register holds one result; while it is full and
//   not taken, non-final bytes are still accepted, and only a last byte waits.
//   Reset (rst, synchronous) clears the packet state and sets both type masks
//   to 0x3E. Type masks are written over the APB port (0x0 v2, 0x4 v3) and
//   should only change between packets.
// ----------------------------------------------------------------------------
`default_nettype none

module ospf_header_checker_core (
  input  wire              clk,
  input  wire              rst,
  // byte input
  input  wire              item_valid,
  output logic             item_ready,
  input  ohc_pkg::item_t   item,
  // result output
  output logic             result_valid,
  input  wire              result_ready,
  output ohc_pkg::result_t result,
  // configuration
  input  wire              psel,
  input  wire              penable,
  input  wire              pwrite,
  input  wire [2:0]        paddr,
  input  wire [31:0]       pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration registers
  logic [7:0] v2_type_mask;
  logic [7:0] v3_type_mask;

  // Packet state
  logic [ohc_pkg::CountW-1:0] byte_count;
  logic [7:0]  version_seen;
  logic [7:0]  type_seen;
  logic [15:0] length_field;
  logic [31:0] router_reg;
  logic [31:0] area_reg;
  logic [15:0] checksum_field;
  logic [15:0] auth_type_reg;
  logic [63:0] auth_data_reg;

  logic [ohc_pkg::CountW-1:0] byte_count_next;
  logic [7:0]  version_next;
  logic [7:0]  type_next;
  logic [15:0] length_next;
  logic [31:0] router_next;
  logic [31:0] area_next;
  logic [15:0] checksum_next;
  logic [15:0] auth_type_next;
  logic [63:0] auth_data_next;

  logic                fire;
  logic                last;
  logic [7:0]          b;
  logic                zero_byte;
  ohc_pkg::csum_step_t step;
  logic [15:0]         final_sum;
  ohc_pkg::result_t    result_next;
  logic                v2;
  logic                v3;
  logic [ohc_pkg::CountW-1:0] hdr_len;
  logic [7:0]          mask_sel;
  logic                type_ok;

  // APB port
  assign pready = 1'b1;
  assign prdata = {24'd0, (paddr[2] == ohc_pkg::REG_V3_MASK) ? v3_type_mask : v2_type_mask};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2_type_mask <= 8'd62;
      v3_type_mask <= 8'd62;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == ohc_pkg::REG_V3_MASK) begin
        v3_type_mask <= pwdata[7:0];
      end else begin
        v2_type_mask <= pwdata[7:0];
      end
    end
  end

  // Handshake: only a last byte needs the result register free
  assign item_ready = !result_valid || result_ready || !item.last_byte;
  assign fire       = item_valid && item_ready;
  assign last       = item.last_byte;
  assign b          = item.data_byte;

  // Header field capture by byte position
  always_comb begin
    version_next   = version_seen;
    type_next      = type_seen;
    length_next    = length_field;
    router_next    = router_reg;
    area_next      = area_reg;
    checksum_next  = checksum_field;
    auth_type_next = auth_type_reg;
    auth_data_next = auth_data_reg;
    if (byte_count == 17'd0) begin
      version_next = b;
    end else if (byte_count == 17'd1) begin
      type_next = b;
    end else if (byte_count <= 17'd3) begin
      length_next = {length_field[7:0], b};
    end else if (byte_count <= 17'd7) begin
      router_next = {router_reg[23:0], b};
    end else if (byte_count <= 17'd11) begin
      area_next = {area_reg[23:0], b};
    end else if (byte_count <= 17'd13) begin
      checksum_next = {checksum_field[7:0], b};
    end else if (byte_count <= 17'd15) begin
      auth_type_next = {auth_type_reg[7:0], b};
    end else if (byte_count <= 17'd23) begin
      auth_data_next = {auth_data_reg[55:0], b};
    end
    byte_count_next = (byte_count < ohc_pkg::COUNT_MAX) ? byte_count + 17'd1 : byte_count;
  end

  // Checksum field, and v2 auth data, sum as zero
  assign zero_byte = (byte_count == 17'd12) || (byte_count == 17'd13) ||
                     ((version_seen == ohc_pkg::VER_2) && (byte_count >= 17'd16) &&
                      (byte_count <= 17'd23));

  always_comb begin
    step.fire  = fire;
    step.pair  = byte_count[0];
    step.pad   = last && byte_count_next[0];
    step.clear = last;
    step.sbyte = zero_byte ? 8'h00 : b;
  end

  ohc_csum u_csum (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .final_sum (final_sum)
  );

  // Verdict, in priority order
  always_comb begin
    v2       = (version_next == ohc_pkg::VER_2);
    v3       = (version_next == ohc_pkg::VER_3);
    hdr_len  = v2 ? ohc_pkg::HDR_V2 : (v3 ? ohc_pkg::HDR_V3 : '0);
    mask_sel = v2 ? v2_type_mask : v3_type_mask;
    type_ok  = (type_next[7:3] == 5'd0) && mask_sel[type_next[2:0]];

    if (byte_count_next < 17'd2) begin
      result_next.status = ohc_pkg::ST_SHORT;
    end else if (!v2 && !v3) begin
      result_next.status = ohc_pkg::ST_BAD_VER;
    end else if (!type_ok) begin
      result_next.status = ohc_pkg::ST_BAD_TYPE;
    end else if (byte_count_next < hdr_len) begin
      result_next.status = ohc_pkg::ST_SHORT;
    end else if ({1'b0, length_next} != byte_count_next) begin
      result_next.status = ohc_pkg::ST_LEN_MISM;
    end else if (~final_sum != checksum_next) begin
      result_next.status = ohc_pkg::ST_CSUM_MISM;
    end else begin
      result_next.status = ohc_pkg::ST_OK;
    end

    result_next.is_v3       = v3;
    result_next.pkt_type    = type_next;
    result_next.router_id   = router_next;
    result_next.area_id     = area_next;
    result_next.auth_type   = v2 ? auth_type_next : 16'd0;
    result_next.auth_data   = v2 ? auth_data_next : 64'd0;
    result_next.instance_id = v3 ? auth_type_next[15:8] : 8'd0;
    result_next.body_offset = hdr_len[4:0];
  end

  // Packet state: advance per byte, clear after the last
  always_ff @(posedge clk) begin
    if (rst || (fire && last)) begin
      byte_count     <= '0;
      version_seen   <= '0;
      type_seen      <= '0;
      length_field   <= '0;
      router_reg     <= '0;
      area_reg       <= '0;
      checksum_field <= '0;
      auth_type_reg  <= '0;
      auth_data_reg  <= '0;
    end else if (fire) begin
      byte_count     <= byte_count_next;
      version_seen   <= version_next;
      type_seen      <= type_next;
      length_field   <= length_next;
      router_reg     <= router_next;
      area_reg       <= area_next;
      checksum_field <= checksum_next;
      auth_type_reg  <= auth_type_next;
      auth_data_reg  <= auth_data_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && last) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  // A last byte transfer always produces a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.last_byte |=> result_valid)
    else $error("no result after last byte");

  // Packet state restarts after the last byte
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.last_byte |=> byte_count == '0)
    else $error("byte count not cleared after packet");

  // A pending result blocks only the last byte
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready && item.last_byte |-> !item_ready)
    else $error("last byte accepted over pending result");

  // A passing packet always has a known version
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ohc_pkg::ST_OK) |->
      (result.body_offset == 5'd24) || (result.body_offset == 5'd16))
    else $error("ok status without a valid header length");
`endif

endmodule

`default_nettype wire
